// ===== sv/sstf_pkg.sv =====
package sstf_pkg;

	localparam int DEF_MAX_REQUESTS  = 64;
	localparam int DEF_CYLINDER_BITS = 12;

	// Fixed widths of the stream fields.
	localparam int FIELD_CYL_W = 12;
	localparam int SUM_W       = 18;
	localparam logic [SUM_W-1:0] SUM_MAX = 18'h3FFFF;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

endpackage

// ===== sv/sstf_disk_scheduler_top.sv =====
// A start beat with N loaded requests produces N result beats; each pick scans
// the request memory through its single read port, then emits one beat once the
// output is free. A start beat with nothing loaded goes straight to the emit
// state and presents a single empty beat, marked last.
// The asynchronous reset clears the request count, the served marks, the
// head and sum, and start_head. The request memory itself is not cleared.
module sstf_disk_scheduler_top #(
	parameter int MAX_REQUESTS  = sstf_pkg::DEF_MAX_REQUESTS,
	parameter int CYLINDER_BITS = sstf_pkg::DEF_CYLINDER_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: cfg_data is start_head.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sstf_pkg::FIELD_CYL_W-1:0]  cfg_data,
	// Input stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [sstf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [11:0] request_cylinder
	input  logic                              s_axis_tuser,  // [0] opcode
	// Output stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [11:0] served_cylinder, [23:12] seek_distance, [41:24] total_seek
	output logic [sstf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tuser,  // [0] empty_batch
	output logic                              m_axis_tlast   // last_served
);

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int CW    = CYLINDER_BITS;
	localparam int FW    = sstf_pkg::FIELD_CYL_W;
	localparam int SW    = sstf_pkg::SUM_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           start_head_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        scan_idx_q;
	logic [CNT_W-1:0]        pick_q;
	logic [MAX_REQUESTS-1:0] served_q;
	logic [CW-1:0]           head_q;
	logic [SW-1:0]           sum_q;
	logic                    empty_q;
	logic                    found_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [CW-1:0]           best_dist_q;
	logic [CW-1:0]           best_cyl_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic [CW-1:0]           rd_data_s1;

	logic                    out_vld_q;
	logic [FW-1:0]           out_cyl_q;
	logic [FW-1:0]           out_dist_q;
	logic [SW-1:0]           out_sum_q;
	logic                    out_empty_q;
	logic                    out_last_q;

	logic [CW-1:0]           request_mem [MAX_REQUESTS];

	logic                    in_beat;
	logic                    out_beat;
	logic                    out_free;
	logic                    emit_now;
	logic                    mem_we;
	logic [CW-1:0]           cand_dist;
	logic                    cand_better;
	logic [SW:0]             sum_wide;
	logic [SW-1:0]           sum_sat;
	logic                    pick_last;
	sstf_pkg::opcode_t       op;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_beat      = m_axis_tvalid && m_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign emit_now      = (state_q == ST_EMIT) && out_free;
	assign op            = sstf_pkg::opcode_t'(s_axis_tuser);
	assign mem_we        = in_beat && (op == sstf_pkg::OP_LOAD)
		&& (count_q < CNT_W'(MAX_REQUESTS));

	assign cand_dist   = (rd_data_s1 >= head_q) ? (rd_data_s1 - head_q) : (head_q - rd_data_s1);
	assign cand_better = !served_q[rd_idx_s1] && (!found_q || (cand_dist < best_dist_q));

	assign sum_wide  = {1'b0, sum_q} + (SW+1)'(best_dist_q);
	assign sum_sat   = sum_wide[SW] ? sstf_pkg::SUM_MAX : sum_wide[SW-1:0];
	assign pick_last = ((pick_q + CNT_W'(1)) == count_q);

	// Request memory: one write port for loads, one registered read port for scans.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			request_mem[count_q[IDX_W-1:0]] <= CW'(s_axis_tdata[FW-1:0]);
		end
		rd_data_s1 <= request_mem[scan_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_head_q <= '0;
			count_q      <= '0;
			scan_idx_q   <= '0;
			pick_q       <= '0;
			served_q     <= '0;
			head_q       <= '0;
			sum_q        <= '0;
			empty_q      <= 1'b0;
			found_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_vld_q    <= 1'b0;
			best_idx_q   <= '0;
			best_dist_q  <= '0;
			best_cyl_q   <= '0;
			rd_idx_s1    <= '0;
			out_cyl_q    <= '0;
			out_dist_q   <= '0;
			out_sum_q    <= '0;
			out_empty_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				start_head_q <= CW'(cfg_data);
			end
			out_vld_q <= emit_now || (out_vld_q && !out_beat);

			// Compare stage of the scan: one candidate per cycle.
			rd_vld_s1 <= (state_q == ST_SCAN) && (scan_idx_q != count_q);
			if (rd_vld_s1 && cand_better) begin
				found_q     <= 1'b1;
				best_idx_q  <= rd_idx_s1;
				best_dist_q <= cand_dist;
				best_cyl_q  <= rd_data_s1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (mem_we) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (in_beat && (op == sstf_pkg::OP_START)) begin
						head_q     <= start_head_q;
						sum_q      <= '0;
						pick_q     <= '0;
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						empty_q    <= (count_q == '0);
						state_q    <= (count_q == '0) ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == count_q) begin
						state_q <= ST_EMIT;
					end else begin
						rd_idx_s1  <= scan_idx_q[IDX_W-1:0];
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (empty_q) begin
							out_cyl_q   <= FW'(start_head_q);
							out_dist_q  <= '0;
							out_sum_q   <= '0;
							out_empty_q <= 1'b1;
							out_last_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							out_cyl_q   <= FW'(best_cyl_q);
							out_dist_q  <= FW'(best_dist_q);
							out_sum_q   <= sum_sat;
							out_empty_q <= 1'b0;
							out_last_q  <= pick_last;
							head_q      <= best_cyl_q;
							sum_q       <= sum_sat;
							if (pick_last) begin
								// The schedule is done: the batch is forgotten.
								count_q  <= '0;
								served_q <= '0;
								state_q  <= ST_IDLE;
							end else begin
								served_q[best_idx_q] <= 1'b1;
								pick_q     <= pick_q + CNT_W'(1);
								scan_idx_q <= '0;
								found_q    <= 1'b0;
								state_q    <= ST_SCAN;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(sstf_pkg::OUT_TDATA_W - 2*FW - SW){1'b0}},
		out_sum_q, out_dist_q, out_cyl_q};
	assign m_axis_tuser  = out_empty_q;
	assign m_axis_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count exceeds the store depth");

	a_marks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(served_q) <= int'(count_q))
		else $error("more served marks than loaded requests");

	a_empty_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (op == sstf_pkg::OP_START) && (count_q == '0))
		|=> (state_q == ST_EMIT) && empty_q)
		else $error("start with no requests did not go to the empty result");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("empty result beat not marked last");

endmodule

// ===== test/sstf_disk_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module sstf_disk_scheduler_top_tb;

	localparam int CLK_PERIOD  = 10;
	localparam int MAX_REQ     = sstf_pkg::DEF_MAX_REQUESTS;
	localparam int CYL_W       = sstf_pkg::FIELD_CYL_W;
	localparam int SETTLE      = 8;
	localparam int LONG_HOLD   = 400;
	localparam int QUIET_LIMIT = 6000;
	localparam logic [CYL_W-1:0] CYL_MAX = '1;

	typedef struct packed {
		logic [CYL_W-1:0]           cyl;
		logic [CYL_W-1:0]           seek;
		logic [sstf_pkg::SUM_W-1:0] total;
		logic                       empty;
		logic                       last;
	} sched_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_mode_t;

	typedef struct packed {
		row_kind_t         kind;
		sstf_pkg::opcode_t op;
		logic [CYL_W-1:0]  value;
		logic              typed;
		sched_result_t     want;
	} dir_row_t;

	localparam sched_result_t NO_RESULT = '0;
	localparam int NUM_DIR_ROWS = 25;

	// Typed rows cover reset, the extremes of the head and the cylinder, and an
	// empty start; the tie, duplicate and mixed rows go through the predictor.
	localparam dir_row_t DIR_TABLE [NUM_DIR_ROWS] = '{
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b1, '{12'd0, 12'd0, 18'd0, 1'b1, 1'b1}},
		'{ROW_CFG,  sstf_pkg::OP_LOAD,  12'd4095, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd4095, 1'b1, '{12'd4095, 12'd0, 18'd0, 1'b1, 1'b1}},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd0, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b1, '{12'd0, 12'd4095, 18'd4095, 1'b0, 1'b1}},
		'{ROW_CFG,  sstf_pkg::OP_LOAD,  12'd0, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd4095, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b1, '{12'd4095, 12'd4095, 18'd4095, 1'b0, 1'b1}},
		'{ROW_CFG,  sstf_pkg::OP_LOAD,  12'd2048, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd2048, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b1, '{12'd2048, 12'd0, 18'd0, 1'b0, 1'b1}},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd1948, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd2148, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd2148, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd1948, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd4095, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd100, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd100, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd4095, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd0, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b0, NO_RESULT},
		'{ROW_CFG,  sstf_pkg::OP_LOAD,  12'd2730, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_LOAD,  12'd1365, 1'b0, NO_RESULT},
		'{ROW_ITEM, sstf_pkg::OP_START, 12'd0, 1'b0, NO_RESULT}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [CYL_W-1:0]                 cfg_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [sstf_pkg::IN_TDATA_W-1:0]  s_axis_tdata;  // [11:0] request_cylinder
	logic                             s_axis_tuser;  // [0] opcode
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	// [11:0] served_cylinder, [23:12] seek_distance, [41:24] total_seek
	logic [sstf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tuser;  // [0] empty_batch
	logic                             m_axis_tlast;  // last_served

	logic [CYL_W-1:0] pending_cyls [$];
	logic [CYL_W-1:0] cfg_head;
	sched_result_t    due_results [$];
	sched_result_t    seen_beat;
	sched_result_t    oldest_due;
	int unsigned      fault_count;
	int unsigned      burst_left;
	int unsigned      hold_requests;
	int unsigned      quiet_cycles;

	sstf_disk_scheduler_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Serves the held requests nearest first; among equal distances the one
	// loaded earliest goes first.
	function automatic void plan_seek_order(sstf_pkg::opcode_t op, logic [CYL_W-1:0] req,
			ref sched_result_t outs [$]);
		logic [CYL_W-1:0]         head;
		logic [CYL_W-1:0]         best_gap;
		logic [CYL_W-1:0]         d;
		logic [sstf_pkg::SUM_W:0] sum;
		bit                       done [MAX_REQ];
		int                       best;
		sched_result_t            r;
		outs.delete();
		if (op == sstf_pkg::OP_LOAD) begin
			if (pending_cyls.size() < MAX_REQ)
				pending_cyls.push_back(req);
			return;
		end
		if (pending_cyls.size() == 0) begin
			r = '{cyl: cfg_head, seek: '0, total: '0, empty: 1'b1, last: 1'b1};
			outs.push_back(r);
			return;
		end
		head = cfg_head;
		sum = '0;
		best_gap = '0;
		foreach (done[i])
			done[i] = 1'b0;
		for (int pick = 0; pick < pending_cyls.size(); pick++) begin
			best = -1;
			for (int j = 0; j < pending_cyls.size(); j++) begin
				if (!done[j]) begin
					d = (pending_cyls[j] >= head) ? pending_cyls[j] - head : head - pending_cyls[j];
					if (best < 0 || d < best_gap) begin
						best = j;
						best_gap = d;
					end
				end
			end
			done[best] = 1'b1;
			sum += (sstf_pkg::SUM_W + 1)'(best_gap);
			if (sum > {1'b0, sstf_pkg::SUM_MAX})
				sum = {1'b0, sstf_pkg::SUM_MAX};
			head = pending_cyls[best];
			r = '{cyl: head, seek: best_gap, total: sum[sstf_pkg::SUM_W-1:0], empty: 1'b0,
				last: (pick == pending_cyls.size() - 1)};
			outs.push_back(r);
		end
		pending_cyls.delete();
	endfunction

	function automatic logic [CYL_W-1:0] pick_cylinder(logic [CYL_W-1:0] prev);
		case ($urandom_range(0, 7))
			0: return prev;
			1: return $urandom_range(0, 1) ? CYL_MAX : '0;
			// Close to the head, so that equal distances come up often.
			2, 3: return cfg_head + CYL_W'($urandom_range(0, 64)) - CYL_W'(32);
			default: return CYL_W'($urandom);
		endcase
	endfunction

	task automatic send_item(sstf_pkg::opcode_t op, logic [CYL_W-1:0] req);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(sstf_pkg::IN_TDATA_W - CYL_W){1'b0}}, req};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_checked(sstf_pkg::opcode_t op, logic [CYL_W-1:0] req);
		sched_result_t outs [$];
		send_item(op, req);
		plan_seek_order(op, req, outs);
		foreach (outs[k])
			due_results.push_back(outs[k]);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_start_head(logic [CYL_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_head = value;
	endtask

	task automatic run_batch(int unsigned n);
		logic [CYL_W-1:0] prev;
		prev = cfg_head;
		repeat (n) begin
			prev = pick_cylinder(prev);
			send_checked(sstf_pkg::OP_LOAD, prev);
		end
		send_checked(sstf_pkg::OP_START, CYL_W'($urandom));
	endtask

	task automatic flag_field(string name, int unsigned want, int unsigned got);
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		fault_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_beat = '{cyl: m_axis_tdata[CYL_W-1:0],
				seek: m_axis_tdata[2*CYL_W-1:CYL_W],
				total: m_axis_tdata[2*CYL_W+sstf_pkg::SUM_W-1:2*CYL_W],
				empty: m_axis_tuser, last: m_axis_tlast};
			if (due_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none, actual cylinder %0d",
					$time, seen_beat.cyl);
				fault_count++;
			end else begin
				oldest_due = due_results.pop_front();
				if (seen_beat.cyl !== oldest_due.cyl)
					flag_field("served_cylinder", oldest_due.cyl, seen_beat.cyl);
				if (seen_beat.seek !== oldest_due.seek)
					flag_field("seek_distance", oldest_due.seek, seen_beat.seek);
				if (seen_beat.total !== oldest_due.total)
					flag_field("total_seek", oldest_due.total, seen_beat.total);
				if (seen_beat.empty !== oldest_due.empty)
					flag_field("empty_batch", oldest_due.empty, seen_beat.empty);
				if (seen_beat.last !== oldest_due.last)
					flag_field("last_served", oldest_due.last, seen_beat.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : receiver
		int unsigned seg_left;
		int unsigned holds_done;
		rx_mode_t    mode;
		seg_left = 0;
		holds_done = 0;
		mode = RX_OPEN;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (seg_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			case (mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) < 7);
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:   m_axis_tready <= ((seg_left % 16) < 4);
			endcase
		end
	end

	initial begin : sender
		sched_result_t    outs [$];
		logic [CYL_W-1:0] prev;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = sstf_pkg::OP_LOAD;
		cfg_head = '0;
		fault_count = 0;
		burst_left = 0;
		hold_requests = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TABLE[i]) begin
			if (DIR_TABLE[i].kind == ROW_CFG) begin
				write_start_head(DIR_TABLE[i].value);
			end else if (DIR_TABLE[i].typed) begin
				send_item(DIR_TABLE[i].op, DIR_TABLE[i].value);
				plan_seek_order(DIR_TABLE[i].op, DIR_TABLE[i].value, outs);
				due_results.push_back(DIR_TABLE[i].want);
			end else begin
				send_checked(DIR_TABLE[i].op, DIR_TABLE[i].value);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_start_head(CYL_MAX);
				1: write_start_head('0);
				default: write_start_head(CYL_W'($urandom));
			endcase
			repeat ($urandom_range(1, 3)) begin
				run_batch($urandom_range(0, 6));
				if ($urandom_range(0, 5) == 0)
					send_checked(sstf_pkg::OP_START, CYL_W'($urandom));
			end
			if (ph == 2) begin
				// Overfill the store, then hold the output off so that the
				// loads offered behind the start back up against the block.
				prev = cfg_head;
				repeat (MAX_REQ + 2) begin
					prev = pick_cylinder(prev);
					send_checked(sstf_pkg::OP_LOAD, prev);
				end
				hold_requests++;
				send_checked(sstf_pkg::OP_START, '0);
				run_batch(3);
			end
			// Loads left waiting here are served by the next start, under the start_head then set.
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3))
					send_checked(sstf_pkg::OP_LOAD, CYL_W'($urandom));
		end
		run_batch($urandom_range(1, 4));

		wait_drained();
		if (fault_count == 0 && due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
